// ===== sv/gb3_pkg.sv =====
`timescale 1ns / 1ps
package gb3_pkg;

  localparam int MAX_SIDE = 4096;
  localparam int COL_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = COL_W + 1;
  localparam int ROW_W    = COL_W + 1;
  localparam int PIX_W    = 8;
  localparam int SUM_W    = PIX_W + 4;

  // floor(x / 9) == (x * RECIP_9) >> RECIP_SH for every x up to 9 * 255
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(7282);

  localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0][2:0] win_t;  // [row][col], col 2 is the newest

  typedef struct packed {
    logic emit;
    logic pre_shift;  // result uses the window before this request shifts it
    logic do_shift;
    logic drain;
    logic at_top;
    logic at_bot;
    logic at_left;
    logic at_right;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic corner;
    logic at_top;
    logic at_left;
    logic last;
  } flt_flags_t;

endpackage

// ===== sv/gb3_if.sv =====
`timescale 1ns / 1ps
interface gb3_in_if;
  import gb3_pkg::*;
  logic valid;
  logic ready;
  logic func;
  pix_t pixel;
  modport source (output valid, output func, output pixel, input ready);
  modport sink (input valid, input func, input pixel, output ready);
endinterface

interface gb3_out_if;
  import gb3_pkg::*;
  logic valid;
  logic ready;
  pix_t blurred;
  logic last_of_frame;
  modport source (output valid, output blurred, output last_of_frame, input ready);
  modport sink (input valid, input blurred, input last_of_frame, output ready);
endinterface

interface gb3_cfg_if;
  import gb3_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] side_length;
  modport source (output valid, output side_length, input ready);
  modport sink (input valid, input side_length, output ready);
endinterface

// ===== sv/gaussian_3x3_replicate_border.sv =====
`timescale 1ns / 1ps
// pipeline: the request that releases a result passes stage 1, stage 2 and the out register;
//   output pixel k is released by input position k + side + 1 (one row plus one pixel)
// throughput: one request per cycle, input stalls only while out backs up through all three
//   stages; line stores are read at accept and written back when the request leaves stage 1
// reset: side_length 4096, frame positions and 3x3 window cleared, line stores not cleared
module gaussian_3x3_replicate_border (
  input  logic         clk,
  input  logic         rst_n,
  gb3_in_if.sink       in_ch,
  gb3_out_if.source    out_ch,
  gb3_cfg_if.sink      cfg_ch
);
  import gb3_pkg::*;

  // position and configuration
  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [COL_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;

  logic      cfg_wr;
  logic      acc;
  logic      take;
  logic      drain;
  logic      row_ge_s;
  logic      effective;
  logic      final_pos;
  logic      in_col_wrap;
  logic      out_col_wrap;
  s1_ctrl_t  s0_ctrl;

  // stage 1: line-store data arrives
  logic      s1_valid_r, s1_valid_nxt;
  s1_ctrl_t  s1_ctrl_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t      s1_pixel_r;
  logic      s1_move;

  pix_t      up_rd;
  pix_t      mid_rd;
  pix_t      bot;
  logic      ram_re;
  logic      ram_we;

  win_t      win_r, win_nxt;
  win_t      src;
  win_t      v_sel;
  logic [1:0] rsel [3];
  logic [1:0] csel [3];

  // stage 2: selected taps
  logic       s2_valid_r, s2_valid_nxt;
  win_t       s2_v_r;
  flt_flags_t s2_flags_r;
  logic       s2_free;

  // output register
  logic       out_valid_r, out_valid_nxt;
  pix_t       out_blurred_r;
  logic       out_last_r;
  logic       out_load;
  pix_t       flt_pix;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;

  assign acc       = in_ch.valid && in_ch.ready;
  assign drain     = (in_ch.func == FUNC_DRAIN);
  assign row_ge_s  = (in_row_r >= side_r);
  assign effective = drain ? row_ge_s : !row_ge_s;
  assign final_pos = (in_row_r > side_r);
  assign take      = acc && effective;

  assign in_col_wrap  = ({1'b0, in_col_r} + SIDE_W'(1)) >= side_r;
  assign out_col_wrap = ({1'b0, out_col_r} + SIDE_W'(1)) >= side_r;

  always_comb begin
    s0_ctrl.emit      = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));
    s0_ctrl.pre_shift = (in_col_r == '0);
    s0_ctrl.do_shift  = !final_pos;
    s0_ctrl.drain     = drain;
    s0_ctrl.at_top    = (out_row_r == '0);
    s0_ctrl.at_bot    = ({1'b0, out_row_r} + SIDE_W'(1)) >= side_r;
    s0_ctrl.at_left   = (out_col_r == '0);
    s0_ctrl.at_right  = out_col_wrap;
    s0_ctrl.last      = s0_ctrl.at_bot && out_col_wrap;
  end

  always_comb begin
    side_nxt    = side_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (cfg_wr) begin
      if (cfg_ch.side_length < SIDE_MIN) begin
        side_nxt = SIDE_MIN;
      end else if (cfg_ch.side_length > SIDE_MAX) begin
        side_nxt = SIDE_MAX;
      end else begin
        side_nxt = cfg_ch.side_length;
      end
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (take) begin
      if (s0_ctrl.emit) begin
        if (out_col_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + COL_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
      if (final_pos) begin
        in_row_nxt  = '0;
        in_col_nxt  = '0;
        out_row_nxt = '0;
        out_col_nxt = '0;
      end else if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_RESET;
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      side_r    <= side_nxt;
      in_row_r  <= in_row_nxt;
      in_col_r  <= in_col_nxt;
      out_row_r <= out_row_nxt;
      out_col_r <= out_col_nxt;
    end
  end

  // line stores: read at accept, written back when the request leaves stage 1
  assign ram_re = take && s0_ctrl.do_shift;
  assign ram_we = s1_move && s1_ctrl_r.do_shift;
  assign bot    = s1_ctrl_r.drain ? mid_rd : s1_pixel_r;

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_ram_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (ram_re),
    .raddr (in_col_r),
    .rdata (up_rd)
  );

  gb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_ram_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_col_r),
    .wdata (bot),
    .re    (ram_re),
    .raddr (in_col_r),
    .rdata (mid_rd)
  );

  assign s1_move      = s1_valid_r && s2_free;
  assign in_ch.ready  = !s1_valid_r || s1_move;
  assign s1_valid_nxt = take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ctrl_r  <= s0_ctrl;
      s1_col_r   <= in_col_r;
      s1_pixel_r <= in_ch.pixel;
    end
  end

  always_comb begin
    win_nxt = win_r;
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = up_rd;
    win_nxt[1][2] = mid_rd;
    win_nxt[2][2] = bot;
  end

  // the first column of a row finishes the previous row's last pixel before shifting
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (s1_ctrl_r.pre_shift) begin
        src[r][0] = win_r[r][1];
        src[r][1] = win_r[r][2];
        src[r][2] = win_r[r][2];
      end else begin
        src[r][0] = win_nxt[r][0];
        src[r][1] = win_nxt[r][1];
        src[r][2] = win_nxt[r][2];
      end
    end
  end

  // border replication
  always_comb begin
    rsel[0] = s1_ctrl_r.at_top ? 2'd1 : 2'd0;
    rsel[1] = 2'd1;
    rsel[2] = s1_ctrl_r.at_bot ? 2'd1 : 2'd2;
    csel[0] = s1_ctrl_r.at_left ? 2'd1 : 2'd0;
    csel[1] = 2'd1;
    csel[2] = s1_ctrl_r.at_right ? 2'd1 : 2'd2;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        v_sel[r][c] = src[rsel[r]][csel[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ram_we) begin
      win_r <= win_nxt;
    end
  end

  assign out_load     = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s2_free      = !s2_valid_r || out_load;
  assign s2_valid_nxt = (s1_move && s1_ctrl_r.emit) ? 1'b1 : (out_load ? 1'b0 : s2_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_ctrl_r.emit) begin
      s2_v_r            <= v_sel;
      s2_flags_r.corner <= (s1_ctrl_r.at_top || s1_ctrl_r.at_bot)
                           && (s1_ctrl_r.at_left || s1_ctrl_r.at_right);
      s2_flags_r.at_top  <= s1_ctrl_r.at_top;
      s2_flags_r.at_left <= s1_ctrl_r.at_left;
      s2_flags_r.last    <= s1_ctrl_r.last;
    end
  end

  gb3_filter u_filter (
    .v       (s2_v_r),
    .flags   (s2_flags_r),
    .blurred (flt_pix)
  );

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_blurred_r <= flt_pix;
      out_last_r    <= s2_flags_r.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.blurred       = out_blurred_r;
  assign out_ch.last_of_frame = out_last_r;

  // a new read never hits the column still waiting for write-back
  a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_re && ram_we) |-> (in_col_r != s1_col_r))
    else $error("line store read and write-back collide on one column");

  a_in_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, in_col_r} < side_r)
    else $error("input column beyond side length");

  a_in_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= (side_r + ROW_W'(1)))
    else $error("input row beyond drain row");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_load) |=> (s2_valid_r && $stable(s2_v_r)))
    else $error("stalled tap stage lost or changed its data");

endmodule

// ===== sv/gb3_ram.sv =====
`timescale 1ns / 1ps
module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/gb3_filter.sv =====
`timescale 1ns / 1ps
module gb3_filter (
  input  gb3_pkg::win_t       v,
  input  gb3_pkg::flt_flags_t flags,
  output gb3_pkg::pix_t       blurred
);
  import gb3_pkg::*;

  function automatic logic [SUM_W-1:0] ext(input pix_t p);
    ext = {{(SUM_W - PIX_W){1'b0}}, p};
  endfunction

  logic [SUM_W-1:0]            sum16;
  logic [SUM_W-1:0]            sum9;
  logic [SUM_W+RECIP_W-1:0]    prod9;
  pix_t                        edge_h;
  pix_t                        edge_v;
  pix_t                        diag;

  // full 1-2-1 kernel, divide by 16
  assign sum16 = ext(v[0][0]) + (ext(v[0][1]) << 1) + ext(v[0][2])
               + (ext(v[1][0]) << 1) + (ext(v[1][1]) << 2) + (ext(v[1][2]) << 1)
               + ext(v[2][0]) + (ext(v[2][1]) << 1) + ext(v[2][2]);

  // corners only see in-frame neighbours, weights sum to 9
  always_comb begin
    edge_h = flags.at_left ? v[1][2] : v[1][0];
    edge_v = flags.at_top ? v[2][1] : v[0][1];
    if (flags.at_top) begin
      diag = flags.at_left ? v[2][2] : v[2][0];
    end else begin
      diag = flags.at_left ? v[0][2] : v[0][0];
    end
  end

  assign sum9  = (ext(v[1][1]) << 2) + (ext(edge_h) << 1) + (ext(edge_v) << 1) + ext(diag);
  assign prod9 = {{RECIP_W{1'b0}}, sum9} * {{SUM_W{1'b0}}, RECIP_9};

  assign blurred = flags.corner ? prod9[RECIP_SH +: PIX_W] : sum16[4 +: PIX_W];

endmodule
